[rtl/q4_block_quant_dot_product_assert.svh]
// Assertion macros for the block quantized dot product.
`ifndef Q4_BLOCK_QUANT_DOT_PRODUCT_ASSERT_SVH
`define Q4_BLOCK_QUANT_DOT_PRODUCT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QDP_ASSERT_NOW(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("Assertion failed.");
`define QDP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("Assertion failed.");
`else
`define QDP_ASSERT_NOW(lbl, cond)
`define QDP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/qdp_pkg.sv]
package qdp_pkg;
    localparam int DEF_MAX_BLOCKS = 256;
    localparam int BLOCK_SIZE = 32;
    localparam int NIB_OFFSET = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCKS_PER_ROW = 2'd0,
        CFG_FIRST_ROW      = 2'd1,
        CFG_END_ROW        = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_ACC
    } t_state;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_WEIGHT = 1'b1;
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
endpackage

[rtl/qdp_in_if.sv]
interface qdp_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  block_index;
    logic [63:0] data_word0;
    logic [63:0] data_word1;
    logic [63:0] data_word2;
    logic [63:0] data_word3;
    logic [15:0] weight_scale_half;
    logic signed [31:0] activation_scale;

    modport source (output valid, mode, block_index, data_word0, data_word1, data_word2,
                    data_word3, weight_scale_half, activation_scale, input ready);
    modport sink (input valid, mode, block_index, data_word0, data_word1, data_word2,
                  data_word3, weight_scale_half, activation_scale, output ready);
endinterface

[rtl/qdp_out_if.sv]
interface qdp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] row_index;
    logic signed [63:0] row_sum;

    modport source (output valid, row_index, row_sum, input ready);
    modport sink (input valid, row_index, row_sum, output ready);
endinterface

[rtl/qdp_act_mem.sv]
module qdp_act_mem #(
    parameter int MAX_BLOCKS = qdp_pkg::DEF_MAX_BLOCKS,
    parameter int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  logic [287:0]   i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output logic [287:0]   o_rdata
);
    logic [287:0] r_mem [MAX_BLOCKS];
    logic [287:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/qdp_term.sv]
module qdp_term (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [127:0]  i_nibbles,
    input  logic [15:0]   i_half,
    input  logic [287:0]  i_act,
    output logic          o_valid,
    output logic signed [63:0] o_term
);
    logic [3:0] r_vld;
    logic signed [16:0] r_dot, n_dot;
    logic [31:0] r_ascale;
    logic [15:0] r_half1, r_half2, r_half3;
    logic [47:0] r_base;
    logic r_neg2, r_neg3;
    logic [58:0] r_p;
    logic r_bzero3;
    logic signed [63:0] r_term, n_term;
    logic neg1;
    logic [15:0] mag_d;
    logic [31:0] mag_a;
    logic [10:0] mant;

    always_comb begin
        logic [7:0] raw;
        logic [3:0] nib;
        logic signed [4:0] wv;
        logic signed [7:0] xv;
        n_dot = '0;
        for (int i = 0; i < qdp_pkg::BLOCK_SIZE; i++) begin
            raw = i_nibbles[8*(i%16) +: 8];
            nib = (i < 16) ? raw[3:0] : raw[7:4];
            wv = $signed({1'b0, nib}) - 5'(qdp_pkg::NIB_OFFSET);
            xv = $signed(i_act[8*i +: 8]);
            n_dot = n_dot + 17'(wv) * 17'(xv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_comb begin
        mag_d = r_dot[16] ? 16'(-r_dot) : r_dot[15:0];
        mag_a = r_ascale[31] ? (32'd0 - r_ascale) : r_ascale;
        neg1 = r_half1[15] ^ r_dot[16] ^ r_ascale[31];
        mant = (r_half2[14:10] == 5'd0) ? {1'b0, r_half2[9:0]} : {1'b1, r_half2[9:0]};
    end

    always_comb begin
        logic [4:0] e;
        logic [4:0] sh;
        logic [63:0] mag;
        e = r_half3[14:10];
        sh = 5'd0;
        if (e >= 5'd25) begin
            mag = 64'(r_p) << (e - 5'd25);
        end else begin
            sh = 5'd25 - ((e == 5'd0) ? 5'd1 : e);
            mag = (64'(r_p) + (64'd1 << (sh - 5'd1))) >> sh;
        end
        if (e == 5'd31) begin
            n_term = r_bzero3 ? 64'sd0 : (r_neg3 ? qdp_pkg::SUM_MIN : qdp_pkg::SUM_MAX);
        end else begin
            n_term = r_neg3 ? -$signed(mag) : $signed(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dot <= n_dot;
            r_ascale <= i_act[287:256];
            r_half1 <= i_half;
        end
        if (r_vld[0]) begin
            r_base <= 48'(mag_d) * 48'(mag_a);
            r_neg2 <= neg1;
            r_half2 <= r_half1;
        end
        if (r_vld[1]) begin
            r_p <= 59'(r_base) * 59'(mant);
            r_bzero3 <= (r_base == 48'd0);
            r_neg3 <= r_neg2;
            r_half3 <= r_half2;
        end
        if (r_vld[2]) begin
            r_term <= n_term;
        end
    end

    assign o_valid = r_vld[3];
    assign o_term = r_term;
endmodule

[rtl/q4_block_quant_dot_product.sv]
// Q4_0 by Q8 block quantized matrix-vector product.
// The input channel carries words of two kinds. A load word (mode 0) stores 32
// activation bytes and their Q8.24 scale in the activation memory slot named by
// block_index. A weight word (mode 1) brings 16 nibble bytes and a half scale.
// Weight words of a row arrive in block order and each is dotted with the
// activation block of the same position; after blocks_per_row words the
// saturated Q40.24 row sum leaves on the output channel with its row index.
// A load word leaves ready high. A weight word for a row before end_row keeps ready
// low after it is accepted until its accumulate step is done, so no further word
// is taken meanwhile; it passes a memory read, one dot product stage, two multiplier
// stages, a rounding shift stage, the term hand-over and the accumulate step.
// Configuration writes on the write port restart the pass at first_row and
// clear the accumulator and block count. Reset does the same with the default
// register values; the activation memory is not cleared and must be loaded
// before it is used. A finished row waits in the output register; while the
// receiver stalls, further words are still taken, and only the word that
// completes the next row waits in the accumulate step until the register frees.
`include "q4_block_quant_dot_product_assert.svh"
module q4_block_quant_dot_product #(
    parameter int MAX_BLOCKS = qdp_pkg::DEF_MAX_BLOCKS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qdp_in_if.sink s_in,
    qdp_out_if.source m_out,
    input  logic i_cfg_we,
    input  logic [qdp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [qdp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BW = $clog2(MAX_BLOCKS + 1);

    qdp_pkg::t_state r_state, n_state;
    logic [8:0] r_bpr;
    logic [15:0] r_first;
    logic [16:0] r_end;
    logic [16:0] r_row;
    logic [AW-1:0] r_cnt;
    logic signed [63:0] r_acc;
    logic [127:0] r_nib;
    logic [15:0] r_half;
    logic r_out_valid;
    logic [15:0] r_out_row;
    logic signed [63:0] r_out_sum;

    logic acc_in, row_ok, last_blk, mem_we, term_vld, do_acc, cfg_hit;
    logic [BW-1:0] bpr_eff;
    logic [AW+7:0] slot_ext;
    logic [287:0] rdata;
    logic signed [63:0] term, sat_sum;
    logic signed [64:0] wide_sum;

    assign acc_in = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == qdp_pkg::S_IDLE);
    assign row_ok = (r_row < r_end) && !r_row[16];
    assign slot_ext = {{AW{1'b0}}, s_in.block_index};
    assign mem_we = acc_in && (s_in.mode == qdp_pkg::MODE_LOAD)
                    && (32'(slot_ext) < MAX_BLOCKS);
    assign cfg_hit = i_cfg_we && (i_cfg_idx == qdp_pkg::CFG_BLOCKS_PER_ROW
                    || i_cfg_idx == qdp_pkg::CFG_FIRST_ROW || i_cfg_idx == qdp_pkg::CFG_END_ROW);

    always_comb begin
        if (r_bpr == 9'd0) begin
            bpr_eff = BW'(1);
        end else if (32'(r_bpr) > MAX_BLOCKS) begin
            bpr_eff = BW'(MAX_BLOCKS);
        end else begin
            bpr_eff = BW'(r_bpr);
        end
    end

    assign last_blk = (32'(r_cnt) + 32'd1) >= 32'(bpr_eff);
    assign wide_sum = 65'(r_acc) + 65'(term);
    always_comb begin
        if (wide_sum[64] != wide_sum[63]) begin
            sat_sum = wide_sum[64] ? qdp_pkg::SUM_MIN : qdp_pkg::SUM_MAX;
        end else begin
            sat_sum = wide_sum[63:0];
        end
    end

    qdp_act_mem #(.MAX_BLOCKS(MAX_BLOCKS), .AW(AW)) u_mem (
        .i_clk(i_clk),
        .i_we(mem_we),
        .i_waddr(slot_ext[AW-1:0]),
        .i_wdata({s_in.activation_scale, s_in.data_word3, s_in.data_word2,
                  s_in.data_word1, s_in.data_word0}),
        .i_re(acc_in),
        .i_raddr(r_cnt),
        .o_rdata(rdata)
    );

    qdp_term u_term (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == qdp_pkg::S_READ),
        .i_nibbles(r_nib),
        .i_half(r_half),
        .i_act(rdata),
        .o_valid(term_vld),
        .o_term(term)
    );

    always_comb begin
        n_state = r_state;
        do_acc = 1'b0;
        case (r_state)
            qdp_pkg::S_IDLE: begin
                if (acc_in && s_in.mode == qdp_pkg::MODE_WEIGHT && row_ok) begin
                    n_state = qdp_pkg::S_READ;
                end
            end
            qdp_pkg::S_READ: begin
                n_state = qdp_pkg::S_WAIT;
            end
            qdp_pkg::S_WAIT: begin
                if (term_vld) begin
                    n_state = qdp_pkg::S_ACC;
                end
            end
            qdp_pkg::S_ACC: begin
                if (!last_blk || !r_out_valid || m_out.ready) begin
                    do_acc = 1'b1;
                    n_state = qdp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qdp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qdp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpr <= 9'd1;
            r_first <= '0;
            r_end <= 17'h10000;
            r_row <= '0;
            r_cnt <= '0;
            r_acc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_hit) begin
                r_cnt <= '0;
                r_acc <= '0;
                case (i_cfg_idx)
                    qdp_pkg::CFG_BLOCKS_PER_ROW: begin
                        r_bpr <= i_cfg_data[8:0];
                        r_row <= {1'b0, r_first};
                    end
                    qdp_pkg::CFG_FIRST_ROW: begin
                        r_first <= i_cfg_data[15:0];
                        r_row <= {1'b0, i_cfg_data[15:0]};
                    end
                    default: begin
                        r_end <= i_cfg_data;
                        r_row <= {1'b0, r_first};
                    end
                endcase
            end else if (do_acc) begin
                if (last_blk) begin
                    r_out_valid <= 1'b1;
                    r_row <= r_row + 17'd1;
                    r_cnt <= '0;
                    r_acc <= '0;
                end else begin
                    r_cnt <= r_cnt + AW'(1);
                    r_acc <= sat_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_nib <= {s_in.data_word1, s_in.data_word0};
            r_half <= s_in.weight_scale_half;
        end
        if (do_acc && last_blk) begin
            r_out_row <= r_row[15:0];
            r_out_sum <= sat_sum;
        end
    end

    assign m_out.valid = r_out_valid;
    assign m_out.row_index = r_out_row;
    assign m_out.row_sum = r_out_sum;

    `QDP_ASSERT_NOW(a_busy_not_ready, (r_state == qdp_pkg::S_IDLE) || !s_in.ready)
    `QDP_ASSERT_NOW(a_cnt_in_range, 32'(r_cnt) < 32'(bpr_eff))
    `QDP_ASSERT_NEXT(a_cfg_restart, cfg_hit, (r_cnt == '0) && (r_acc == 64'sd0))
    `QDP_ASSERT_NEXT(a_wait_leads_acc, (r_state == qdp_pkg::S_WAIT) && term_vld,
                     r_state == qdp_pkg::S_ACC)
endmodule

[dv/q4_block_quant_dot_product_tb.sv]
`timescale 1ns / 1ps

module q4_block_quant_dot_product_tb;
    import qdp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int TARGET_WORDS = 1850;

    typedef enum {OP_WORD, OP_CFG, OP_DRAIN} t_op_kind;

    typedef struct {
        t_op_kind    kind;
        logic        mode;
        logic [7:0]  slot;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [15:0] half;
        logic [31:0] ascale;
        int          gap;
        t_cfg_idx    cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
    } t_op;

    typedef struct {
        logic [15:0] row_index;
        logic [63:0] row_sum;
    } t_row_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qdp_in_if in_if ();
    qdp_out_if out_if ();

    q4_block_quant_dot_product dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (in_if.sink),
        .m_out     (out_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    t_op         pending_ops[$];
    t_row_result expected_rows[$];
    int          mismatches = 0;

    // Predictor state.
    byte         act_mem[256][32];
    logic [31:0] act_scale_mem[256];
    logic [8:0]  blocks_per_row;
    logic [15:0] first_row;
    logic [16:0] end_row;
    logic signed [63:0] row_acc;
    int          block_cnt;
    int          cur_row;

    // Stimulus generation state.
    bit          slot_loaded[256];
    bit          gen_quiet = 0;
    int          words_made = 0;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? SUM_MIN : SUM_MAX;
        return s;
    endfunction

    function automatic logic signed [63:0] scaled_term(int dot, logic [15:0] h, logic [31:0] asc);
        logic [31:0] neg_asc;
        longint unsigned mag_a, mag_d, base, m, p, mag;
        logic [4:0] e;
        int ex;
        int sh;
        bit neg;
        neg_asc = -asc;
        mag_a = asc[31] ? {32'b0, neg_asc} : {32'b0, asc};
        mag_d = (dot < 0) ? longint'(-dot) : longint'(dot);
        e = h[14:10];
        neg = h[15] ^ (dot < 0) ^ asc[31];
        base = mag_d * mag_a;
        if (e == 5'h1F) begin
            if (base == 0) return 64'sd0;
            return neg ? SUM_MIN : SUM_MAX;
        end
        m = (e == 0) ? {54'b0, h[9:0]} : {53'b0, 1'b1, h[9:0]};
        ex = ((e == 0) ? 1 : int'(e)) - 25;
        p = base * m;
        if (ex >= 0) begin
            mag = p << ex;
        end else begin
            sh = -ex;
            mag = (p + (64'd1 << (sh - 1))) >> sh;
        end
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic void restart_pass();
        cur_row = first_row;
        row_acc = 0;
        block_cnt = 0;
    endfunction

    function automatic void apply_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BLOCKS_PER_ROW: blocks_per_row = data[8:0];
            CFG_FIRST_ROW:      first_row = data[15:0];
            CFG_END_ROW:        end_row = data[16:0];
            default: return;
        endcase
        restart_pass();
    endfunction

    function automatic void accept_word();
        logic [255:0] bytes_all;
        logic [7:0] raw;
        int eb, b, dot, bi, wv;
        if (in_if.mode == MODE_LOAD) begin
            bytes_all = {in_if.data_word3, in_if.data_word2, in_if.data_word1, in_if.data_word0};
            for (int k = 0; k < 32; k++) act_mem[in_if.block_index][k] = bytes_all[8*k +: 8];
            act_scale_mem[in_if.block_index] = in_if.activation_scale;
            return;
        end
        if (cur_row >= end_row || cur_row > 65535) return;
        eb = (blocks_per_row == 0) ? 1 : blocks_per_row;
        if (eb > DEF_MAX_BLOCKS) eb = DEF_MAX_BLOCKS;
        b = (block_cnt >= eb) ? eb - 1 : block_cnt;
        dot = 0;
        for (int i = 0; i < BLOCK_SIZE; i++) begin
            bi = i % 16;
            raw = (bi < 8) ? in_if.data_word0[8*bi +: 8] : in_if.data_word1[8*(bi-8) +: 8];
            wv = ((i < 16) ? int'(raw[3:0]) : int'(raw[7:4])) - NIB_OFFSET;
            dot += wv * int'(act_mem[b][i]);
        end
        row_acc = sat_add(row_acc, scaled_term(dot, in_if.weight_scale_half, act_scale_mem[b]));
        if (b + 1 >= eb) begin
            expected_rows.push_back('{row_index: cur_row[15:0], row_sum: row_acc});
            cur_row++;
            row_acc = 0;
            block_cnt = 0;
        end else begin
            block_cnt = b + 1;
        end
    endfunction

    // Prediction and checking.
    always @(posedge i_clk) begin
        t_row_result exp_row;
        if (!i_rst_n) begin
            blocks_per_row = 1;
            first_row = 0;
            end_row = 17'h10000;
            restart_pass();
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row result, actual row %0d sum %0h",
                             $time, out_if.row_index, out_if.row_sum);
                    mismatches++;
                end else begin
                    exp_row = expected_rows.pop_front();
                    if (out_if.row_index !== exp_row.row_index) begin
                        $display("%0t: row_index expected %0d actual %0d",
                                 $time, exp_row.row_index, out_if.row_index);
                        mismatches++;
                    end
                    if (out_if.row_sum !== exp_row.row_sum) begin
                        $display("%0t: row_sum expected %0h actual %0h",
                                 $time, exp_row.row_sum, out_if.row_sum);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) apply_cfg(i_cfg_idx, i_cfg_data);
            if (in_if.valid && in_if.ready) accept_word();
        end
    end

    // Driver.
    int   gap_left = 0;
    int   settle = 0;
    logic next_valid;
    logic next_we;
    t_op  cur_op;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left = 0;
            settle = 0;
        end else begin
            next_we = 1'b0;
            if (in_if.valid || expected_rows.size() != 0) settle = 0;
            else settle++;
            if (!(in_if.valid && !in_if.ready)) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() > 0) begin
                    case (pending_ops[0].kind)
                        OP_WORD: begin
                            cur_op = pending_ops.pop_front();
                            next_valid = 1'b1;
                            in_if.mode <= cur_op.mode;
                            in_if.block_index <= cur_op.slot;
                            in_if.data_word0 <= cur_op.w0;
                            in_if.data_word1 <= cur_op.w1;
                            in_if.data_word2 <= cur_op.w2;
                            in_if.data_word3 <= cur_op.w3;
                            in_if.weight_scale_half <= cur_op.half;
                            in_if.activation_scale <= cur_op.ascale;
                            gap_left = cur_op.gap;
                        end
                        OP_DRAIN: begin
                            if (expected_rows.size() == 0) void'(pending_ops.pop_front());
                        end
                        OP_CFG: begin
                            if (settle >= SETTLE_CYCLES) begin
                                cur_op = pending_ops.pop_front();
                                next_we = 1'b1;
                                i_cfg_idx <= cur_op.cfg_idx;
                                i_cfg_data <= cur_op.cfg_data;
                                settle = 0;
                            end
                        end
                    endcase
                end
                in_if.valid <= next_valid;
            end
            i_cfg_we <= next_we;
        end
    end

    // Result receiver with random stalls.
    int stall_left = 0;
    int quiet_timer = 0;
    bit sink_quiet = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            quiet_timer++;
            if (quiet_timer >= 300) begin
                quiet_timer = 0;
                sink_quiet = ($urandom_range(0, 3) == 0);
            end
            if (out_if.valid && out_if.ready) stall_left = sink_quiet ? 0 : $urandom_range(0, 7);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake or configuration write.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("q4_block_quant_dot_product_tb: errors");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_half();
        logic [4:0] e;
        case ($urandom_range(0, 9))
            0: e = 5'h1F;
            1: e = 5'h00;
            default: e = $urandom_range(1, 30);
        endcase
        return {1'($urandom), e, 10'($urandom)};
    endfunction

    function automatic int pick_gap();
        return gen_quiet ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic void push_load(logic [7:0] slot, logic [63:0] w0, logic [63:0] w1,
                                      logic [63:0] w2, logic [63:0] w3, logic [31:0] asc);
        t_op op;
        op = '{kind: OP_WORD, mode: MODE_LOAD, slot: slot, w0: w0, w1: w1, w2: w2, w3: w3,
               half: 16'($urandom), ascale: asc, gap: pick_gap(),
               cfg_idx: CFG_BLOCKS_PER_ROW, cfg_data: '0};
        pending_ops.push_back(op);
        slot_loaded[slot] = 1;
        words_made++;
    endfunction

    function automatic void push_weight(logic [63:0] w0, logic [63:0] w1, logic [15:0] h);
        t_op op;
        op = '{kind: OP_WORD, mode: MODE_WEIGHT, slot: 8'($urandom), w0: w0, w1: w1,
               w2: rand64(), w3: rand64(), half: h, ascale: $urandom, gap: pick_gap(),
               cfg_idx: CFG_BLOCKS_PER_ROW, cfg_data: '0};
        pending_ops.push_back(op);
        words_made++;
    endfunction

    function automatic void push_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        t_op op;
        op = '{kind: OP_CFG, mode: MODE_LOAD, slot: '0, w0: '0, w1: '0, w2: '0, w3: '0,
               half: '0, ascale: '0, gap: 0, cfg_idx: idx, cfg_data: data};
        pending_ops.push_back(op);
    endfunction

    function automatic void push_drain();
        t_op op;
        op = '{kind: OP_DRAIN, mode: MODE_LOAD, slot: '0, w0: '0, w1: '0, w2: '0, w3: '0,
               half: '0, ascale: '0, gap: 0, cfg_idx: CFG_BLOCKS_PER_ROW, cfg_data: '0};
        pending_ops.push_back(op);
    endfunction

    function automatic logic [63:0] rand_act_word();
        case ($urandom_range(0, 7))
            0: return {8{8'h80}};
            1: return {8{8'h7F}};
            default: return rand64();
        endcase
    endfunction

    function automatic logic [31:0] rand_ascale();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_nibbles();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return {64{1'b1}};
            default: return rand64();
        endcase
    endfunction

    function automatic void gen_directed();
        push_load(8'd0, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, {8{8'h80}}, 32'h8000_0000);
        push_load(8'd1, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, {8{8'h7F}}, 32'h7FFF_FFFF);
        push_load(8'd255, rand64(), rand64(), rand64(), rand64(), 32'h0100_0000);
        push_weight(64'h0, 64'h0, 16'h3C00);
        push_weight({64{1'b1}}, {64{1'b1}}, 16'h7C00);
        push_weight(64'h0, 64'h0, 16'hFE00);
        push_weight(rand64(), rand64(), 16'h0001);
        push_weight(64'h0, 64'h0, 16'h7BFF);
        push_weight(rand64(), rand64(), 16'h0000);
        push_weight(rand64(), rand64(), 16'h8000);
        push_cfg(CFG_BLOCKS_PER_ROW, 17'd0);
        push_weight(rand64(), rand64(), 16'h3C00);
        push_cfg(CFG_BLOCKS_PER_ROW, 17'd2);
        // Both blocks add large positive terms; the row sum comes close to the positive limit but does not saturate.
        push_weight(64'h0, 64'h0, 16'hFBFF);
        push_weight(64'h0, 64'h0, 16'hFBFF);
        push_weight(64'h0, 64'h0, 16'h7BFF);
        push_weight(64'h0, 64'h0, 16'h7BFF);
        push_cfg(CFG_BLOCKS_PER_ROW, 17'd1);
        push_cfg(CFG_FIRST_ROW, 17'hFFFF);
        push_cfg(CFG_END_ROW, 17'h10000);
        push_weight(rand64(), rand64(), 16'h3C00);
        push_weight(rand64(), rand64(), 16'h3C00);
        push_cfg(CFG_END_ROW, 17'd0);
        push_weight(rand64(), rand64(), 16'h3C00);
        push_drain();
    endfunction

    function automatic void gen_phase(bit force_max);
        logic [CFG_DATA_W-1:0] bpr_val;
        logic [15:0] fr;
        logic [16:0] er;
        int eb, nrows, partial;
        gen_quiet = ($urandom_range(0, 4) == 0);
        if (force_max) bpr_val = 17'd511;
        else case ($urandom_range(0, 19))
            0: bpr_val = 17'd256;
            1: bpr_val = 17'd0;
            default: bpr_val = $urandom_range(1, 6);
        endcase
        eb = (bpr_val == 0) ? 1 : ((bpr_val > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : bpr_val);
        fr = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(65520, 65535)) : 16'($urandom);
        case ($urandom_range(0, 5))
            0: er = 17'h10000;
            1: er = 17'($urandom);
            default: er = 17'(fr) + 17'($urandom_range(0, 30));
        endcase
        push_cfg(CFG_BLOCKS_PER_ROW, bpr_val);
        push_cfg(CFG_FIRST_ROW, 17'(fr));
        push_cfg(CFG_END_ROW, er);
        for (int s = 0; s < eb; s++) begin
            if (!slot_loaded[s] || $urandom_range(0, 7) == 0)
                push_load(8'(s), rand_act_word(), rand_act_word(), rand_act_word(),
                          rand_act_word(), rand_ascale());
        end
        nrows = (eb >= 64) ? $urandom_range(1, 2) : $urandom_range(3, 30);
        for (int r = 0; r < nrows; r++) begin
            if (!force_max && words_made >= TARGET_WORDS) break;
            for (int b = 0; b < eb; b++) begin
                if ($urandom_range(0, 9) == 0)
                    push_load(8'($urandom), rand_act_word(), rand_act_word(), rand_act_word(),
                              rand_act_word(), rand_ascale());
                push_weight(rand_nibbles(), rand_nibbles(), rand_half());
            end
            if ($urandom_range(0, 24) == 0) push_drain();
        end
        if (eb > 1 && $urandom_range(0, 2) == 0) begin
            partial = $urandom_range(1, eb - 1);
            for (int b = 0; b < partial; b++)
                push_weight(rand_nibbles(), rand_nibbles(), rand_half());
        end
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BLOCKS_PER_ROW;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.mode = MODE_LOAD;
        in_if.block_index = '0;
        in_if.data_word0 = '0;
        in_if.data_word1 = '0;
        in_if.data_word2 = '0;
        in_if.data_word3 = '0;
        in_if.weight_scale_half = '0;
        in_if.activation_scale = '0;
        out_if.ready = 1'b0;
        gen_directed();
        gen_phase(1'b1);
        while (words_made < TARGET_WORDS) gen_phase(1'b0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (pending_ops.size() != 0 || in_if.valid);
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_rows.size() == 0) begin
            $display("q4_block_quant_dot_product_tb: clean");
        end else begin
            $display("q4_block_quant_dot_product_tb: errors");
        end
        $finish;
    end
endmodule
